// File: hdl/lfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared constants, types and helpers of the lagged-Fibonacci generator.
// ----------------------------------------------------------------------------
package lfg_pkg;

  localparam int LONG_LAG   = 55;
  localparam int SHORT_LAG  = 24;
  localparam int MID_LAG    = LONG_LAG - SHORT_LAG;
  localparam int SEED_STEP  = 21;
  localparam int WARMUP     = 5;
  localparam int WORD_W     = 31;
  localparam int ADDR_W     = $clog2(LONG_LAG + 1);
  localparam int PASS_W     = $clog2(WARMUP + 1);

  localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(LONG_LAG);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  seed_load;  // capture seed, write top entry
    logic  fill_step;  // write one fill entry, advance fill recurrence
    logic  rd_en;      // read both ports into the read registers
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  rgn_wr;     // write a - b to wr_addr
    addr_t wr_addr;
    logic  rp_set;     // read position back to LONG_LAG - 1
    logic  rp_dec;     // read position down by one
    logic  out_load;   // load port-a read data into the output register
  } lfg_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic  fill_last;  // current fill step is the last one
    logic  rp_ok;      // read position points at an unused entry
    addr_t rp;
    logic  out_free;   // output register can take a result this cycle
  } lfg_stat_t;

  function automatic word_t sub31(input word_t a, input word_t b);
    sub31 = a - b;
  endfunction

endpackage

// File: hdl/lfg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfg_dp
// Datapath: lag table memory, seed fill recurrence, read position, output.
// ----------------------------------------------------------------------------
module lfg_dp import lfg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lfg_cmd_t          cmd,
  input  logic [31:0]       seed_value,
  output lfg_stat_t         stat,
  output logic              out_valid,
  output word_t             out_data,
  input  logic              out_ready
);

  // lag table, entries 1..LONG_LAG used
  word_t mem [0:LONG_LAG];
  logic [LONG_LAG:0] vld_r;

  word_t rda_r, rdb_r;
  logic  vla_r, vlb_r;
  word_t opa, opb;

  // fill recurrence
  word_t prev_r, next_r, seed_r;
  addr_t fi_r;
  word_t seed_rot;
  logic [ADDR_W:0] fi_sum;
  addr_t fi_nxt;

  addr_t rp_r;
  logic  out_valid_r;
  word_t out_data_r;

  logic  wr_en;
  addr_t wr_addr;
  word_t wr_data;

  assign opa = vla_r ? rda_r : '0;
  assign opb = vlb_r ? rdb_r : '0;

  assign seed_rot = {seed_r[0], seed_r[WORD_W-1:1]};
  assign fi_sum   = {1'b0, fi_r} + (ADDR_W+1)'(SEED_STEP);
  assign fi_nxt   = (fi_sum >= (ADDR_W+1)'(LONG_LAG)) ?
                    ADDR_W'(fi_sum - (ADDR_W+1)'(LONG_LAG)) : ADDR_W'(fi_sum);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd.wr_addr;
    wr_data = sub31(opa, opb);
    if (cmd.seed_load) begin
      wr_en   = 1'b1;
      wr_addr = TOP_ADDR;
      wr_data = seed_value[WORD_W-1:0];
    end else if (cmd.fill_step) begin
      wr_en   = 1'b1;
      wr_addr = fi_r;
      wr_data = next_r;
    end else if (cmd.rgn_wr) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rda_r <= mem[cmd.rd_addr_a];
      rdb_r <= mem[cmd.rd_addr_b];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vla_r <= 1'b0;
      vlb_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        vla_r <= vld_r[cmd.rd_addr_a];
        vlb_r <= vld_r[cmd.rd_addr_b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      prev_r <= seed_value[WORD_W-1:0];
      seed_r <= seed_value[WORD_W-1:0];
      next_r <= WORD_W'(1);
      fi_r   <= ADDR_W'(SEED_STEP);
    end else if (cmd.fill_step) begin
      prev_r <= next_r;
      seed_r <= seed_rot;
      next_r <= sub31(sub31(prev_r, next_r), seed_rot);
      fi_r   <= fi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.rp_set) begin
        rp_r <= TOP_ADDR - ADDR_W'(1);
      end else if (cmd.rp_dec) begin
        rp_r <= rp_r - ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= opa;
    end
  end

  assign stat.fill_last = (fi_nxt == '0);
  assign stat.rp_ok     = (rp_r != '0) && (rp_r <= TOP_ADDR);
  assign stat.rp        = rp_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/lfg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfg_ctrl
// Controller: sequences seed fill, regeneration sweeps and number delivery.
// ----------------------------------------------------------------------------
module lfg_ctrl import lfg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  input  lfg_stat_t stat,
  output lfg_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_RGN_RD = 3'd2;
  localparam logic [2:0] S_RGN_WR = 3'd3;
  localparam logic [2:0] S_TOP_RD = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]        state_r, state_nxt;
  addr_t             step_r, step_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic              seeding_r, seeding_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    pass_nxt    = pass_r;
    seeding_nxt = seeding_r;
    cmd         = '0;
    cmd.wr_addr   = step_r;
    cmd.rd_addr_a = step_r;
    cmd.rd_addr_b = (step_r <= ADDR_W'(SHORT_LAG)) ? step_r + ADDR_W'(MID_LAG)
                                                    : step_r - ADDR_W'(SHORT_LAG);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            cmd.seed_load = 1'b1;
            state_nxt     = S_FILL;
          end else if (stat.rp_ok) begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = stat.rp;
            cmd.rp_dec    = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            step_nxt    = ADDR_W'(1);
            pass_nxt    = PASS_W'(1);
            seeding_nxt = 1'b0;
            state_nxt   = S_RGN_RD;
          end
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          step_nxt    = ADDR_W'(1);
          pass_nxt    = PASS_W'(WARMUP);
          seeding_nxt = 1'b1;
          state_nxt   = S_RGN_RD;
        end
      end
      S_RGN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RGN_WR;
      end
      S_RGN_WR: begin
        cmd.rgn_wr = 1'b1;
        if (step_r == TOP_ADDR) begin
          step_nxt = ADDR_W'(1);
          if (pass_r == PASS_W'(1)) begin
            cmd.rp_set = 1'b1;
            state_nxt  = seeding_r ? S_IDLE : S_TOP_RD;
          end else begin
            pass_nxt  = pass_r - PASS_W'(1);
            state_nxt = S_RGN_RD;
          end
        end else begin
          step_nxt  = step_r + ADDR_W'(1);
          state_nxt = S_RGN_RD;
        end
      end
      S_TOP_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = TOP_ADDR;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= ADDR_W'(1);
      pass_r    <= '0;
      seeding_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      pass_r    <= pass_nxt;
      seeding_r <= seeding_nxt;
    end
  end

endmodule

// File: hdl/lagged_fibonacci_subtractive_rng_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_fibonacci_subtractive_rng_unit
// Subtractive lagged-Fibonacci generator, lags 55 and 24, modulo 2^31.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry the mode in in_tuser (0 = load seed, 1 = next
//   number) and the seed word in in_tdata (low 31 bits used, mode 0 only).
//   Each mode 1 request yields one 31-bit number on out_tdata; a seed
//   request yields nothing.
//   Sequence: a next-number request served from the table does one memory
//   read, then one output load once the output register is free. Every 55th
//   request regenerates the table: 55 read/write steps, each a read then a
//   write, on the single table memory. A seed request writes the top entry,
//   then 54 fill entries, then runs five regeneration sweeps.
//   One request is processed at a time; in_tready is high only while idle.
//   The output register frees the engine: a new request is taken while a
//   result still waits on a stalled receiver, and its result waits inside.
//   Reset clears the read position (table exhausted) and marks every table
//   entry unwritten, so the table reads as all zero until a seed is loaded.
// ----------------------------------------------------------------------------
module lagged_fibonacci_subtractive_rng_unit import lfg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed_value
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [30:0] random_value, [31] zero
);

  lfg_cmd_t  cmd;
  lfg_stat_t stat;
  word_t     rnd;

  // sequence fill, sweeps and delivery
  lfg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the table, the fill recurrence and the output register
  lfg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .seed_value (in_tdata),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_data   (rnd),
    .out_ready  (out_tready)
  );

  assign out_tdata = {1'b0, rnd};

  // only one table write source at a time
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.seed_load, cmd.fill_step, cmd.rgn_wr}))
    else $error("more than one table write source active");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  // an accepted seed request starts the fill on the next cycle
  a_seed_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> cmd.fill_step)
    else $error("seed request did not start the fill");

  // read position stays within the table
  a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.rp <= TOP_ADDR)
    else $error("read position out of range");

endmodule
